### hw/rtl/rbb_pkg.sv
package rbb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 7;

  localparam logic [2:0]  RADIUS_RST = 3'd7;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red_mean;
    logic [7:0] green_mean;
    logic [7:0] blue_mean;
    logic       frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [12:0] data;
  } cfg_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [16:0] count;
  } div_ctl_t;

endpackage

### hw/rtl/rbb_stream_if.sv
interface rbb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rbb_ram.sv
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/rbb_lane.sv
module rbb_lane (
  input  logic        clk,
  input  logic        clr,
  input  logic        add,
  input  logic [7:0]  pix,
  input  logic        div_start,
  input  logic [16:0] count,
  output logic [7:0]  mean,
  output logic        done
);
  logic [21:0] sum_r;
  logic [22:0] rem_r;
  logic [22:0] quo_r;
  logic [4:0]  bit_r;
  logic        busy_r;
  logic [23:0] trial;
  logic [23:0] num;

  assign num   = {1'b0, sum_r, 1'b0} + 24'(count);
  assign trial = {rem_r, quo_r[22]} - {6'd0, count, 1'b0};

  always_ff @(posedge clk) begin
    if (clr) begin
      sum_r <= '0;
    end else if (add) begin
      sum_r <= sum_r + 22'(pix);
    end
    if (div_start) begin
      rem_r  <= '0;
      quo_r  <= num[22:0];
      bit_r  <= 5'd23;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (!trial[23]) begin
        rem_r <= trial[22:0];
        quo_r <= {quo_r[21:0], 1'b1};
      end else begin
        rem_r <= {rem_r[21:0], quo_r[22]};
        quo_r <= {quo_r[21:0], 1'b0};
      end
      bit_r <= bit_r - 5'd1;
      if (bit_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = !busy_r;
  assign mean = (quo_r > 23'd255) ? 8'd255 : quo_r[7:0];
endmodule

### hw/rtl/rgb_box_blur.sv
// Output: after the releasing beat the block clears, reads each window pixel
// from the row store, accumulates, divides in all three lanes and offers the beat.
// Throughput: one pixel per cycle while no output is being formed; input ready
// stays low from the releasing beat until the output beat is taken.
// Reset: synchronous, active low; radius 7, width 640, height 480,
// counters cleared. The row store is not cleared.
module rgb_box_blur #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rbb_stream_if.sink   in_ch,
  rbb_stream_if.source out_ch,
  rbb_stream_if.sink   cfg_ch
);
  localparam int ROWS  = 2 * MAX_RADIUS + 2;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  rbb_pkg::state_t state_r, state_nxt;
  logic [2:0]  radius_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [12:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic [12:0] y_r, x_r, y0_r, y1_r, x0_r, x1_r;
  logic [16:0] cnt_r;
  logic        lst_r;
  rbb_pkg::out_beat_t obeat_r;

  logic [12:0] w, h, r;
  logic [25:0] total, recv, sent, delay;
  logic [25:0] recv1;
  logic        acc_pix, ready_go, in_fire;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0] rdata;
  logic [7:0]  m0, m1, m2;
  logic        d0, d1, d2;
  logic        rd_valid_r;
  logic        read_last;
  rbb_pkg::div_ctl_t dctl;

  assign r = (32'(radius_r) > MAX_RADIUS) ? 13'(MAX_RADIUS) : 13'(radius_r);
  assign w = (width_r == 0) ? 13'd1 :
             (32'(width_r) > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(width_r);
  assign h = (height_r == 0) ? 13'd1 : height_r;
  assign total = w * h;
  assign recv  = in_row_r * w + 26'(in_col_r);
  assign sent  = out_row_r * w + 26'(out_col_r);
  assign delay = r * w + 26'((r < w - 13'd1) ? r : w - 13'd1);
  assign recv1 = recv + 26'd1;

  assign in_ch.ready  = (state_r == rbb_pkg::ST_IDLE);
  assign cfg_ch.ready = (state_r == rbb_pkg::ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign acc_pix = in_fire && in_ch.data.command == rbb_pkg::CMD_PIXEL && recv < total;
  assign ready_go = acc_pix ?
                    ((recv1 == total) ? (sent < total) : (recv1 - sent > delay)) :
                    ((recv == total) && (sent < total));

  assign we    = acc_pix;
  assign waddr = AW'((32'(in_row_r) % ROWS) * MAX_WIDTH + (32'(in_col_r) % MAX_WIDTH));
  assign raddr = AW'((32'(y_r) % ROWS) * MAX_WIDTH + (32'(x_r) % MAX_WIDTH));
  assign read_last = (y_r == y1_r) && (x_r == x1_r);

  rbb_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
    .clk, .we, .waddr,
    .wdata({in_ch.data.blue_in, in_ch.data.green_in, in_ch.data.red_in}),
    .raddr, .rdata
  );

  assign dctl.start = (state_r == rbb_pkg::ST_ACC) && !rd_valid_r;
  assign dctl.count = cnt_r;

  rbb_lane u_red (.clk, .clr(state_r == rbb_pkg::ST_CLEAR), .add(rd_valid_r),
    .pix(rdata[7:0]), .div_start(dctl.start), .count(dctl.count), .mean(m0), .done(d0));
  rbb_lane u_grn (.clk, .clr(state_r == rbb_pkg::ST_CLEAR), .add(rd_valid_r),
    .pix(rdata[15:8]), .div_start(dctl.start), .count(dctl.count), .mean(m1), .done(d1));
  rbb_lane u_blu (.clk, .clr(state_r == rbb_pkg::ST_CLEAR), .add(rd_valid_r),
    .pix(rdata[23:16]), .div_start(dctl.start), .count(dctl.count), .mean(m2), .done(d2));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbb_pkg::ST_IDLE:  if (in_fire && ready_go) state_nxt = rbb_pkg::ST_CLEAR;
      rbb_pkg::ST_CLEAR: state_nxt = rbb_pkg::ST_READ;
      rbb_pkg::ST_READ:  if (read_last) state_nxt = rbb_pkg::ST_ACC;
      rbb_pkg::ST_ACC:   if (!rd_valid_r) state_nxt = rbb_pkg::ST_DIV;
      rbb_pkg::ST_DIV:   if (d0 && d1 && d2) state_nxt = rbb_pkg::ST_OUT;
      rbb_pkg::ST_OUT:   if (out_ch.ready) state_nxt = rbb_pkg::ST_IDLE;
      default:           state_nxt = rbb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_ch.valid = (state_r == rbb_pkg::ST_OUT);
    out_ch.data  = obeat_r;
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= (state_r == rbb_pkg::ST_READ);
    if (state_r == rbb_pkg::ST_IDLE) begin
      y0_r  <= (out_row_r > r) ? out_row_r - r : 13'd0;
      y1_r  <= (14'(out_row_r) + 14'(r) < 14'(h) - 14'd1) ? out_row_r + r : h - 13'd1;
      x0_r  <= (out_col_r > r) ? out_col_r - r : 13'd0;
      x1_r  <= (out_col_r + r < w - 13'd1) ? out_col_r + r : w - 13'd1;
      lst_r <= (sent + 26'd1 == total);
    end
    if (state_r == rbb_pkg::ST_CLEAR) begin
      y_r   <= y0_r;
      x_r   <= x0_r;
      cnt_r <= 17'((y1_r - y0_r + 13'd1) * (x1_r - x0_r + 13'd1));
    end else if (state_r == rbb_pkg::ST_READ) begin
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + 13'd1;
      end else begin
        x_r <= x_r + 13'd1;
      end
    end
    if (state_r == rbb_pkg::ST_DIV) begin
      obeat_r <= '{red_mean: m0, green_mean: m1, blue_mean: m2, frame_end: lst_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rbb_pkg::ST_IDLE;
      radius_r  <= rbb_pkg::RADIUS_RST;
      width_r   <= rbb_pkg::WIDTH_RST;
      height_r  <= rbb_pkg::HEIGHT_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data.index == rbb_pkg::REG_RADIUS ||
            cfg_ch.data.index == rbb_pkg::REG_WIDTH ||
            cfg_ch.data.index == rbb_pkg::REG_HEIGHT) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end
        unique case (cfg_ch.data.index)
          rbb_pkg::REG_RADIUS: radius_r <= cfg_ch.data.data[2:0];
          rbb_pkg::REG_WIDTH:  width_r  <= cfg_ch.data.data[10:0];
          rbb_pkg::REG_HEIGHT: height_r <= cfg_ch.data.data;
          default: ;
        endcase
      end else begin
        if (acc_pix) begin
          if (in_col_r + 13'd1 >= w) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 13'd1;
          end else begin
            in_col_r <= in_col_r + 13'd1;
          end
        end
        if (state_r == rbb_pkg::ST_OUT && out_ch.ready) begin
          if (lst_r) begin
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end else if (out_col_r + 13'd1 >= w) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 13'd1;
          end else begin
            out_col_r <= out_col_r + 13'd1;
          end
        end
      end
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> state_r == rbb_pkg::ST_OUT) else $error("out valid off state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != rbb_pkg::ST_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbb_pkg::ST_READ |-> (y_r <= y1_r && x_r <= x1_r)) else $error("read past window");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbb_pkg::ST_DIV |-> cnt_r != 17'd0) else $error("zero count");
endmodule

### bench/tb_rgb_box_blur.sv
`timescale 1ns / 100ps

module tb_rgb_box_blur;

  localparam int STORE_ROWS = 2 * rbb_pkg::MAX_RADIUS_DEF + 2;
  localparam int QUIET_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst_n;

  rbb_stream_if #(.T(rbb_pkg::in_beat_t))  in_ch ();
  rbb_stream_if #(.T(rbb_pkg::out_beat_t)) out_ch ();
  rbb_stream_if #(.T(rbb_pkg::cfg_beat_t)) cfg_ch ();

  rgb_box_blur u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [23:0] row_mem [0:STORE_ROWS*rbb_pkg::MAX_WIDTH_DEF-1];
  int unsigned blur_radius, frame_w, frame_h;
  int unsigned in_col, in_row, out_col, out_row;
  rbb_pkg::out_beat_t mean_q[$];

  int errors;
  int beats_sent;
  int means_seen;
  int frames_done;
  longint cycles;
  bit idle_en;
  bit stall_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d means outstanding", cycles, mean_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_err(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int unsigned eff_radius();
    return blur_radius > rbb_pkg::MAX_RADIUS_DEF ? rbb_pkg::MAX_RADIUS_DEF : blur_radius;
  endfunction

  function automatic int unsigned eff_width();
    if (frame_w == 0) return 1;
    return frame_w > rbb_pkg::MAX_WIDTH_DEF ? rbb_pkg::MAX_WIDTH_DEF : frame_w;
  endfunction

  function automatic int unsigned eff_height();
    return frame_h == 0 ? 1 : frame_h;
  endfunction

  function automatic bit drain_pending();
    int unsigned total;
    total = eff_width() * eff_height();
    return (in_row * eff_width() + in_col == total) &&
           (out_row * eff_width() + out_col < total);
  endfunction

  task automatic model_reg(logic [1:0] idx, logic [12:0] data);
    case (idx)
      rbb_pkg::REG_RADIUS: blur_radius = data[2:0];
      rbb_pkg::REG_WIDTH:  frame_w = data[10:0];
      rbb_pkg::REG_HEIGHT: frame_h = data;
      default: return;
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic model_beat(rbb_pkg::in_beat_t b);
    int unsigned w, h, r, total, recv, sent, delay;
    int unsigned y0, y1, x0, x1, cnt, sr, sg, sb, m;
    logic [23:0] px;
    bit fire;
    rbb_pkg::out_beat_t o;
    w = eff_width(); h = eff_height(); r = eff_radius();
    total = w * h;
    recv = in_row * w + in_col;
    sent = out_row * w + out_col;
    delay = r * w + (r < w - 1 ? r : w - 1);
    if (b.command == rbb_pkg::CMD_PIXEL && recv < total) begin
      row_mem[(in_row % STORE_ROWS) * rbb_pkg::MAX_WIDTH_DEF + in_col] =
        {b.blue_in, b.green_in, b.red_in};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      recv++;
      fire = (recv == total) ? (sent < total) : (recv - sent > delay);
    end else begin
      fire = (recv == total) && (sent < total);
    end
    if (!fire) return;
    y0 = out_row > r ? out_row - r : 0;
    y1 = out_row + r < h - 1 ? out_row + r : h - 1;
    x0 = out_col > r ? out_col - r : 0;
    x1 = out_col + r < w - 1 ? out_col + r : w - 1;
    cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
    sr = 0; sg = 0; sb = 0;
    for (int unsigned y = y0; y <= y1; y++) begin
      for (int unsigned x = x0; x <= x1; x++) begin
        px = row_mem[(y % STORE_ROWS) * rbb_pkg::MAX_WIDTH_DEF + x];
        sr += px[7:0];
        sg += px[15:8];
        sb += px[23:16];
      end
    end
    m = (2 * sr + cnt) / (2 * cnt);
    o.red_mean = m > 255 ? 8'd255 : m[7:0];
    m = (2 * sg + cnt) / (2 * cnt);
    o.green_mean = m > 255 ? 8'd255 : m[7:0];
    m = (2 * sb + cnt) / (2 * cnt);
    o.blue_mean = m > 255 ? 8'd255 : m[7:0];
    o.frame_end = (sent + 1 == total);
    mean_q.push_back(o);
    if (sent + 1 == total) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  always @(posedge clk) begin
    rbb_pkg::out_beat_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      means_seen++;
      if (got.frame_end) frames_done++;
      if (mean_q.size() == 0) begin
        report_err($sformatf("unexpected beat %h", got));
      end else begin
        want = mean_q.pop_front();
        if (got.red_mean !== want.red_mean)
          report_err($sformatf("red %0d want %0d", got.red_mean, want.red_mean));
        if (got.green_mean !== want.green_mean)
          report_err($sformatf("green %0d want %0d", got.green_mean, want.green_mean));
        if (got.blue_mean !== want.blue_mean)
          report_err($sformatf("blue %0d want %0d", got.blue_mean, want.blue_mean));
        if (got.frame_end !== want.frame_end)
          report_err($sformatf("frame_end %0b want %0b", got.frame_end, want.frame_end));
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_en && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(rbb_pkg::in_beat_t b);
    if (idle_en && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    model_beat(b);
    beats_sent++;
  endtask

  function automatic rbb_pkg::in_beat_t rand_pixel();
    rbb_pkg::in_beat_t b;
    b.command = rbb_pkg::CMD_PIXEL;
    b.red_in = 8'($urandom); b.green_in = 8'($urandom); b.blue_in = 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      b.red_in = {8{b.red_in[0]}};
      b.green_in = {8{b.green_in[0]}};
      b.blue_in = {8{b.blue_in[0]}};
    end
    return b;
  endfunction

  function automatic rbb_pkg::in_beat_t drain_tick();
    rbb_pkg::in_beat_t b;
    b = rand_pixel();
    b.command = rbb_pkg::CMD_DRAIN;
    return b;
  endfunction

  // hold input until every mean is out and the block has gone quiet
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (mean_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    rbb_pkg::cfg_beat_t c;
    c.index = idx;
    c.data  = 13'($urandom);
    case (idx)
      rbb_pkg::REG_RADIUS: c.data[2:0] = val[2:0];
      rbb_pkg::REG_WIDTH:  c.data[10:0] = val[10:0];
      rbb_pkg::REG_HEIGHT: c.data = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    model_reg(c.index, c.data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // configure, stream a frame with some noise, then drain it if the whole frame was sent
  task automatic run_frame(int unsigned r, int unsigned w, int unsigned h,
                           int unsigned keep);
    int unsigned total, sent;
    wait_quiet();
    write_reg(rbb_pkg::REG_RADIUS, 13'(r));
    write_reg(rbb_pkg::REG_WIDTH, 13'(w));
    write_reg(rbb_pkg::REG_HEIGHT, 13'(h));
    total = eff_width() * eff_height();
    sent = 0;
    while (sent < total && sent < keep) begin
      if ($urandom_range(0, 24) == 0) begin
        send_beat(drain_tick());
      end else begin
        send_beat(rand_pixel());
        sent++;
      end
    end
    if (sent < total) return;
    while (drain_pending()) begin
      if ($urandom_range(0, 6) == 0) send_beat(rand_pixel());
      else send_beat(drain_tick());
    end
  endtask

  task automatic test_directed();
    rbb_pkg::in_beat_t b;
    wait_quiet();
    write_reg(rbb_pkg::REG_RADIUS, 13'd1);
    write_reg(rbb_pkg::REG_WIDTH, 13'd3);
    write_reg(rbb_pkg::REG_HEIGHT, 13'd2);
    for (int i = 0; i < 6; i++) begin
      b.command = rbb_pkg::CMD_PIXEL;
      b.red_in = (i % 2) ? 8'hFF : 8'h00;
      b.green_in = 8'hFF;
      b.blue_in = (i < 3) ? 8'h00 : 8'h80;
      send_beat(b);
      if (i == 1) send_beat(drain_tick());
    end
    send_beat(rand_pixel());
    while (drain_pending()) send_beat(drain_tick());
    send_beat(drain_tick());
    run_frame(0, 0, 0, 1);
    run_frame(7, 15, 15, 225);
  endtask

  task automatic test_abandon_and_spare();
    run_frame(2, 6, 6, 25);
    wait_quiet();
    write_reg(REG_SPARE, 13'($urandom));
    for (int i = 0; i < 11; i++) send_beat(rand_pixel());
    while (drain_pending()) send_beat(drain_tick());
    run_frame(3, 9, 8, 40);
  endtask

  task automatic test_large_sizes();
    run_frame(0, 11'h7FF, 1, 40);
    run_frame(1, 1, 13'h1004, 40);
    run_frame(7, 1024, 13'h1FFF, 0);
  endtask

  task automatic test_random_frames(int unsigned beats);
    int unsigned start;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      if ($urandom_range(0, 7) == 0)
        run_frame($urandom_range(0, 7), $urandom_range(0, 16),
                  $urandom_range(0, 10), $urandom_range(0, 40));
      else
        run_frame($urandom_range(0, 7), $urandom_range(0, 16),
                  $urandom_range(0, 10), 9999);
    end
  endtask

  initial begin
    errors = 0; beats_sent = 0; means_seen = 0; frames_done = 0; cycles = 0;
    idle_en = 1'b1; stall_en = 1'b1;
    blur_radius = rbb_pkg::RADIUS_RST;
    frame_w = rbb_pkg::WIDTH_RST;
    frame_h = rbb_pkg::HEIGHT_RST;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_abandon_and_spare();
    test_large_sizes();
    test_random_frames(400);
    idle_en = 1'b0;
    stall_en = 1'b0;
    test_random_frames(200);
    wait_quiet();

    $display("blur run: %0d input beats, %0d means checked, %0d frames completed",
             beats_sent, means_seen, frames_done);
    $display("radius 0..7, widths 0..2047, heights up to 8191, abandoned frames, drains");
    if (errors == 0 && mean_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
